// File: src/itt_pkg.sv
`timescale 1ns / 1ps
// Package for the three-channel interval timer: item kinds, decoded commands,
// engine state codes and shared widths. No dependencies.
package itt_pkg;

  localparam int unsigned NumCh   = 3;
  localparam int unsigned CntW    = 16;
  localparam int unsigned AccW    = 17;
  localparam int unsigned QDepth  = 2;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindAdv   = 2'd2,
    KindPoll  = 2'd3
  } kind_e;

  localparam logic [1:0] PortCtrl = 2'd3;
  localparam logic [1:0] ModeLsb  = 2'd1;
  localparam logic [1:0] ModeMsb  = 2'd2;
  localparam logic [1:0] ModeBoth = 2'd3;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  port;
    logic [7:0]  data;
    logic [15:0] cycles;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StChan,
    StMod,
    StDone
  } eng_state_e;

endpackage

// File: src/interval_timer_three_channel.sv
`timescale 1ns / 1ps
// Three-channel 16-bit interval timer, top level. One item is carried out at
// a time. A read, write or poll result is registered onto the result ports
// as the engine takes its command from the queue. An advance result appears
// after a serial divide of the cycle accumulator by the tick rate, then a
// step per channel, plus a serial modulo for each channel that expires. A
// waiting result stalls the engine, and the two-entry command queue then
// fills and raises full.
// Depends on itt_pkg, itt_front, itt_engine.
module interval_timer_three_channel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  port_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] cycles_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data_o,
  output logic        irq_pending_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import itt_pkg::*;

  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;
  logic [15:0] cpt_q;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cpt_q <= 16'd4;
    else if (cfg_valid) cpt_q <= cfg_data;
  end

  itt_front u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .port_i, .write_data_i, .cycles_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  itt_engine u_engine (
    .clk_i, .rst_ni, .cpt_i(cpt_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_take_o(cmd_take), .res_valid_o(res_valid), .res_data_o(read_data_o),
    .res_irq_o(irq_pending_o), .res_take_i(pop && !empty)
  );

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid) else $error("take without command");
  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped");
endmodule

// File: src/itt_front.sv
`timescale 1ns / 1ps
// Front end: accepts item beats and holds them in a short command queue.
// Depends on itt_pkg.
module itt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    kind_i,
  input  logic [1:0]    port_i,
  input  logic [7:0]    write_data_i,
  input  logic [15:0]   cycles_i,
  output logic          cmd_valid_o,
  output itt_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import itt_pkg::*;

  cmd_t       mem_q [QDepth];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;

  assign full        = (cnt_q == 2'(QDepth));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = cmd_take_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(cmd_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= '{kind: kind_e'(kind_i), port: port_i, data: write_data_i,
                       cycles: cycles_i};
    end
  end
endmodule

// File: src/itt_engine.sv
`timescale 1ns / 1ps
// Back end: executes commands against the timer state; serial divide and
// serial modulo for cycle advances. Depends on itt_pkg.
module itt_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   cpt_i,
  input  logic          cmd_valid_i,
  input  itt_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          res_valid_o,
  output logic [7:0]    res_data_o,
  output logic          res_irq_o,
  input  logic          res_take_i
);
  import itt_pkg::*;

  eng_state_e  st_q, st_d;
  logic [15:0] rl_q [NumCh];
  logic [15:0] ct_q [NumCh];
  logic [1:0]  md_q [NumCh];
  logic [2:0]  hb_q, la_q;
  logic [15:0] lc_q [NumCh];
  logic        irq_q;
  logic [16:0] acc_q;
  logic [16:0] quo_q, rem_q;
  logic [4:0]  bit_q;
  logic [1:0]  ch_q;
  logic [16:0] ov_q;
  logic [16:0] mrem_q;
  logic        rv_q, rirq_q;
  logic [7:0]  rd_q;

  logic [16:0] cpt;
  logic [16:0] acc_sum;
  logic [17:0] shl;
  logic [16:0] rl_ext, ct_ext;
  logic [16:0] tks;
  logic        wrap;
  logic [17:0] mshl;
  logic [16:0] mrem_nx;

  assign cpt        = (cpt_i == '0) ? 17'd1 : {1'b0, cpt_i};
  assign acc_sum    = acc_q + {1'b0, cmd_i.cycles};
  assign shl        = {rem_q, quo_q[16]};
  assign rl_ext     = (rl_q[ch_q] == '0) ? 17'h10000 : {1'b0, rl_q[ch_q]};
  assign ct_ext     = (ct_q[ch_q] == '0) ? 17'h10000 : {1'b0, ct_q[ch_q]};
  assign tks        = quo_q;
  assign wrap       = (tks >= ct_ext);
  assign mshl       = {mrem_q, ov_q[16]};
  assign mrem_nx    = (mshl >= {1'b0, rl_ext}) ? 17'(mshl - {1'b0, rl_ext}) : mshl[16:0];
  assign cmd_take_o = (st_q == StIdle) && cmd_valid_i && !rv_q;
  assign res_valid_o = rv_q;
  assign res_data_o  = rd_q;
  assign res_irq_o   = rirq_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (cmd_take_o && cmd_i.kind == KindAdv) st_d = StDiv;
      StDiv:  if (bit_q == 5'd0) st_d = StChan;
      StChan: begin
        if (wrap) st_d = StMod;
        else if (ch_q == 2'd2) st_d = StDone;
        else st_d = StChan;
      end
      StMod:  if (bit_q == 5'd0) st_d = (ch_q == 2'd2) ? StDone : StChan;
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      for (int i = 0; i < NumCh; i++) begin
        rl_q[i] <= 16'hFFFF;
        ct_q[i] <= 16'hFFFF;
        md_q[i] <= ModeBoth;
        lc_q[i] <= '0;
      end
      hb_q   <= '0;
      la_q   <= '0;
      irq_q  <= 1'b0;
      acc_q  <= '0;
      rv_q   <= 1'b0;
      rd_q   <= '0;
      rirq_q <= 1'b0;
      quo_q  <= '0;
      rem_q  <= '0;
      bit_q  <= '0;
      ch_q   <= '0;
      ov_q   <= '0;
      mrem_q <= '0;
    end else begin
      st_q <= st_d;
      if (res_take_i) rv_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (cmd_take_o) begin
            rd_q   <= '0;
            rirq_q <= 1'b0;
            rv_q   <= (cmd_i.kind != KindAdv);
            case (cmd_i.kind)
              KindRead: begin
                if (cmd_i.port == PortCtrl) begin
                  rd_q <= 8'hFF;
                end else begin
                  logic [15:0] v;
                  logic [1:0]  c;
                  c = cmd_i.port;
                  v = la_q[c] ? lc_q[c] : ct_q[c];
                  if (md_q[c] == ModeLsb) begin
                    rd_q <= v[7:0]; la_q[c] <= 1'b0;
                  end else if (md_q[c] == ModeMsb) begin
                    rd_q <= v[15:8]; la_q[c] <= 1'b0;
                  end else if (hb_q[c]) begin
                    rd_q <= v[15:8]; hb_q[c] <= 1'b0; la_q[c] <= 1'b0;
                  end else begin
                    rd_q <= v[7:0]; hb_q[c] <= 1'b1;
                  end
                end
              end
              KindWrite: begin
                if (cmd_i.port == PortCtrl) begin
                  logic [1:0] c;
                  c = cmd_i.data[7:6];
                  if (c != PortCtrl) begin
                    if (cmd_i.data[5:4] == 2'd0) begin
                      if (!la_q[c]) begin
                        la_q[c] <= 1'b1; lc_q[c] <= ct_q[c];
                      end
                    end else begin
                      md_q[c] <= cmd_i.data[5:4]; hb_q[c] <= 1'b0;
                    end
                  end
                end else begin
                  logic [1:0]  c;
                  logic [15:0] lo, hi;
                  c  = cmd_i.port;
                  lo = {rl_q[c][15:8], cmd_i.data};
                  hi = {cmd_i.data, rl_q[c][7:0]};
                  if (md_q[c] == ModeLsb) begin
                    rl_q[c] <= lo; ct_q[c] <= lo;
                  end else if (md_q[c] == ModeMsb) begin
                    rl_q[c] <= hi; ct_q[c] <= hi;
                  end else if (hb_q[c]) begin
                    rl_q[c] <= hi; ct_q[c] <= hi; hb_q[c] <= 1'b0;
                  end else begin
                    rl_q[c] <= lo; hb_q[c] <= 1'b1;
                  end
                end
              end
              KindAdv: begin
                quo_q <= acc_sum;
                rem_q <= '0;
                bit_q <= 5'd16;
              end
              KindPoll: begin
                rirq_q <= irq_q;
                irq_q  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        StDiv: begin
          if (shl >= {1'b0, cpt}) begin
            rem_q <= 17'(shl - {1'b0, cpt});
            quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            rem_q <= shl[16:0];
            quo_q <= {quo_q[15:0], 1'b0};
          end
          bit_q <= bit_q - 5'd1;
          ch_q  <= '0;
        end
        StChan: begin
          acc_q <= rem_q;
          if (wrap) begin
            if (ch_q == 2'd0) irq_q <= 1'b1;
            ov_q   <= tks - ct_ext;
            mrem_q <= '0;
            bit_q  <= 5'd16;
          end else begin
            ct_q[ch_q] <= 16'(ct_ext - tks);
            ch_q <= ch_q + 2'd1;
          end
        end
        StMod: begin
          mrem_q <= mrem_nx;
          ov_q   <= {ov_q[15:0], 1'b0};
          bit_q  <= bit_q - 5'd1;
          if (bit_q == 5'd0) begin
            ct_q[ch_q] <= 16'(rl_ext - mrem_nx);
            ch_q <= ch_q + 2'd1;
          end
        end
        StDone: rv_q <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for interval_timer_three_channel: directed and random bus,
// advance and poll items are checked against an in-bench timer predictor.
// Depends on itt_pkg and the timer RTL.
module tb_top;
  import itt_pkg::*;

  localparam logic [1:0] AccLatch   = 2'd0;
  localparam logic [1:0] ChReadback = 2'd3;

  typedef struct {
    logic [7:0] rd;
    logic       irq;
  } timer_result_t;

  class timer_scoreboard;
    int unsigned   tick_rate;
    logic [15:0]   reload[3];
    logic [15:0]   count[3];
    logic [1:0]    mode[3];
    bit            hi_next[3];
    bit            latched[3];
    logic [15:0]   latch_val[3];
    bit            irq;
    int unsigned   acc;
    timer_result_t pending_q[$];
    int unsigned   errors;
    int unsigned   beats;
    int unsigned   irq_seen;

    function new();
      tick_rate = 4;
      for (int i = 0; i < 3; i++) begin
        reload[i] = 16'hFFFF;
        count[i] = 16'hFFFF;
        mode[i] = ModeBoth;
        hi_next[i] = 0;
        latched[i] = 0;
        latch_val[i] = '0;
      end
      irq = 0;
      acc = 0;
      errors = 0;
      beats = 0;
      irq_seen = 0;
    endfunction

    function void set_rate(logic [15:0] v);
      tick_rate = v;
    endfunction

    function logic [7:0] bus_read(logic [1:0] ch);
      logic [15:0] v;
      logic [7:0]  r;
      if (ch == PortCtrl) return 8'hFF;
      v = latched[ch] ? latch_val[ch] : count[ch];
      if (mode[ch] == ModeLsb) begin
        r = v[7:0];
        latched[ch] = 0;
      end else if (mode[ch] == ModeMsb) begin
        r = v[15:8];
        latched[ch] = 0;
      end else if (hi_next[ch]) begin
        r = v[15:8];
        hi_next[ch] = 0;
        latched[ch] = 0;
      end else begin
        r = v[7:0];
        hi_next[ch] = 1;
      end
      return r;
    endfunction

    function void bus_write(logic [1:0] p, logic [7:0] d);
      logic [1:0] ch;
      if (p == PortCtrl) begin
        ch = d[7:6];
        if (ch == ChReadback) return;
        if (d[5:4] == AccLatch) begin
          if (!latched[ch]) begin
            latched[ch] = 1;
            latch_val[ch] = count[ch];
          end
        end else begin
          mode[ch] = d[5:4];
          hi_next[ch] = 0;
        end
        return;
      end
      ch = p;
      if (mode[ch] == ModeLsb) begin
        reload[ch][7:0] = d;
        count[ch] = reload[ch];
      end else if (mode[ch] == ModeMsb || hi_next[ch]) begin
        reload[ch][15:8] = d;
        count[ch] = reload[ch];
        hi_next[ch] = 0;
      end else begin
        reload[ch][7:0] = d;
        hi_next[ch] = 1;
      end
    endfunction

    function void advance(logic [15:0] cyc);
      int unsigned cpt, ticks, rl, ct;
      cpt = (tick_rate == 0) ? 1 : tick_rate;
      acc = (acc + cyc) & 32'h1FFFF;
      if (acc < cpt) return;
      ticks = acc / cpt;
      acc = acc % cpt;
      for (int i = 0; i < 3; i++) begin
        rl = (reload[i] == 0) ? 32'h10000 : reload[i];
        ct = (count[i] == 0) ? 32'h10000 : count[i];
        if (ticks >= ct) begin
          if (i == 0) irq = 1;
          count[i] = 16'((rl - (ticks - ct) % rl));
        end else begin
          count[i] = 16'(ct - ticks);
        end
      end
    endfunction

    function void note_item(kind_e k, logic [1:0] p, logic [7:0] d, logic [15:0] cyc);
      timer_result_t e;
      e.rd = '0;
      e.irq = 0;
      case (k)
        KindRead: e.rd = bus_read(p);
        KindWrite: bus_write(p, d);
        KindAdv: advance(cyc);
        default: begin
          e.irq = irq;
          irq = 0;
        end
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_beat(logic [7:0] rd, logic irq_o);
      timer_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat rd=%0h irq=%0b", rd, irq_o);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      beats++;
      if (irq_o) irq_seen++;
      if (rd !== e.rd) begin
        $error("read_data mismatch: expected %0h actual %0h", e.rd, rd);
        errors++;
      end
      if (irq_o !== e.irq) begin
        $error("irq_pending mismatch: expected %0b actual %0b", e.irq, irq_o);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [1:0]  kind_i = '0;
  logic [1:0]  port_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [15:0] cycles_i = '0;
  logic        empty;
  logic        pop = 0;
  logic [7:0]  read_data_o;
  logic        irq_pending_o;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  timer_scoreboard sb = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_rx = 0;
  int unsigned items = 0;

  interval_timer_three_channel u_top (
    .clk_i, .rst_ni, .push, .full, .kind_i, .port_i, .write_data_i, .cycles_i,
    .empty, .pop, .read_data_o, .irq_pending_o, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_beat(read_data_o, irq_pending_o);
    pop <= !hold_rx && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(kind_e k, logic [1:0] p, logic [7:0] d, logic [15:0] cyc);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk_i);
    end
    push <= 1;
    kind_i <= k;
    port_i <= p;
    write_data_i <= d;
    cycles_i <= cyc;
    do @(posedge clk_i); while (full);
    sb.note_item(k, p, d, cyc);
    items++;
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_rate(v);
  endtask

  task automatic hold_off(int unsigned n);
    hold_rx = 1;
    repeat (n) @(posedge clk_i);
    hold_rx = 0;
  endtask

  task automatic random_items(int unsigned n);
    int unsigned sel;
    logic [1:0]  ch;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      ch = 2'($urandom_range(2));
      if (sel < 10) begin
        send_item(KindWrite, PortCtrl, {ch, 2'($urandom_range(1, 3)), 4'($urandom)}, '0);
      end else if (sel < 16) begin
        send_item(KindWrite, PortCtrl, {ch, AccLatch, 4'($urandom)}, '0);
        send_item(KindRead, ch, 8'($urandom), '0);
        send_item(KindRead, ch, 8'($urandom), '0);
      end else if (sel < 30) begin
        send_item(KindWrite, ch, 8'($urandom), 16'($urandom));
        send_item(KindWrite, ch, 8'($urandom), 16'($urandom));
      end else if (sel < 48) begin
        send_item(KindRead, 2'($urandom), 8'($urandom), 16'($urandom));
      end else if (sel < 75) begin
        send_item(KindAdv, 2'($urandom), 8'($urandom), 16'($urandom_range(0, 400)));
      end else if (sel < 78) begin
        send_item(KindAdv, 2'($urandom), 8'($urandom), 16'($urandom));
      end else if (sel < 90) begin
        send_item(KindPoll, 2'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        send_item(KindWrite, PortCtrl, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_item(KindRead, PortCtrl, '0, '0);
    send_item(KindWrite, PortCtrl, 8'hC0, '0);
    send_item(KindRead, 2'd0, '0, '0);
    send_item(KindRead, 2'd0, '0, '0);
    send_item(KindWrite, PortCtrl, 8'h00, '0);
    send_item(KindAdv, '0, '0, 16'd40);
    send_item(KindWrite, PortCtrl, 8'h00, '0);
    send_item(KindRead, 2'd0, '0, '0);
    send_item(KindRead, 2'd0, '0, '0);
    send_item(KindWrite, PortCtrl, 8'h50, '0);
    send_item(KindWrite, 2'd1, 8'h00, '0);
    send_item(KindWrite, PortCtrl, 8'h40, '0);
    send_item(KindRead, 2'd1, '0, '0);
    send_item(KindWrite, PortCtrl, 8'hA0, '0);
    send_item(KindWrite, 2'd2, 8'h00, '0);
    send_item(KindWrite, 2'd0, 8'h10, '0);
    send_item(KindWrite, 2'd0, 8'h00, '0);
    send_item(KindAdv, '0, '0, 16'd2);
    send_item(KindAdv, '0, '0, 16'hFFFF);
    send_item(KindRead, 2'd2, '0, '0);
    send_item(KindPoll, '0, '0, '0);
    send_item(KindPoll, '0, '0, '0);

    write_rate(16'd1);
    send_idle = 37;
    recv_idle = 68;
    fork
      hold_off(400);
      random_items(480);
    join

    write_rate(16'hFFFF);
    send_idle = 68;
    recv_idle = 37;
    random_items(480);

    write_rate(16'($urandom_range(2, 12)));
    send_idle = 0;
    recv_idle = 0;
    random_items(480);

    drain();
    $display("Covered %0d items and %0d result beats over four tick rates,", items, sb.beats);
    $display("with %0d interrupt polls returning a pending flag.", sb.irq_seen);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top failed");
    $finish;
  end
endmodule
